@@ design/tftprr_pkg.sv @@
// Shared types and codes for the TFTP read-transfer receiver.
// No dependencies; imported by tftp_read_receiver.
`default_nettype none

package tftprr_pkg;

    // Input packet kinds (slave tuser)
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_OACK  = 2'd3;

    // Packet to send (master tuser)
    localparam logic [1:0] SK_NONE = 2'd0;
    localparam logic [1:0] SK_ACK  = 2'd1;
    localparam logic [1:0] SK_ERR  = 2'd2;
    localparam logic [1:0] SK_RRQ  = 2'd3;

    // TFTP error codes reported
    localparam logic [1:0] EC_ILLEGAL  = 2'd0;
    localparam logic [1:0] EC_REFUSED  = 2'd1;
    localparam logic [1:0] EC_DISKFULL = 2'd2;

    // Transfer state codes
    localparam logic [2:0] TS_RUN      = 3'd0;
    localparam logic [2:0] TS_DALLY    = 3'd1;
    localparam logic [2:0] TS_OK       = 3'd2;
    localparam logic [2:0] TS_XFER_ERR = 3'd3;
    localparam logic [2:0] TS_OPT_ERR  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_DALLY_EN   = 3'd0;
    localparam logic [2:0] CFG_BLKSIZE_ON = 3'd1;
    localparam logic [2:0] CFG_BLKSIZE_RQ = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_ON = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT_RQ = 3'd4;
    localparam logic [2:0] CFG_TSIZE_ON   = 3'd5;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] ack_block;
        logic [1:0]  error_code;
        logic [2:0]  transfer_state;
        logic        deliver_data;
        logic        timeout_apply;
    } t_result;

    // A block shorter than the limit ends the transfer.
    function automatic logic [2:0] f_end_state(input logic [15:0] size,
                                               input logic [15:0] limit,
                                               input logic        dally);
        logic [2:0] st;
        st = TS_RUN;
        if (size < limit) begin
            st = dally ? TS_DALLY : TS_OK;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

@@ design/tftp_read_receiver.sv @@
// TFTP read-transfer receiver: sequence, block size and option checking.
// Depends on tftprr_pkg for codes, the result struct and the end-of-transfer test.
//
// Usage: each word on the slave stream is one decoded packet header; tuser
// carries the packet kind (start, DATA, ACK, OACK) and tdata its fields. For
// every accepted word exactly one word leaves on the master stream: tuser is
// the packet to send, tdata the ACK block, error code, transfer state and the
// deliver and timeout-apply flags.
// A word accepted at a clock edge is presented on the master side in the next
// cycle. One word is accepted per cycle unless stalled; the only state that
// one word hands to the next (last block, block limit, OACK seen) is updated
// in the same cycle by the compare logic in front of the output register.
// The output register is the only buffer: while a result waits and the master
// side holds tready low, s_axis_tready drops; when the result is taken the
// next word is accepted in that same cycle.
// Reset (synchronous, active low) empties the output register, clears the
// last block and OACK flag, sets the block limit to DEFAULT_BLOCK and loads
// the configuration defaults. The user writes configuration through i_cfg_*
// only while no word is in flight; the block itself does not enforce this.
`default_nettype none

module tftp_read_receiver
    import tftprr_pkg::*;
#(
    parameter int DEFAULT_BLOCK = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    // packet header stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // block_number[15:0], data_size[31:16], options_accepted[32],
    // option_list_empty[33], blksize_valid[34], blksize_value[50:35],
    // timeout_valid[51], timeout_value[59:52], tsize_valid[60],
    // tsize_fits[61], zero fill[63:62]
    input  wire logic [63:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // response stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // ack_block[15:0], error_code[17:16], transfer_state[20:18],
    // deliver_data[21], timeout_apply[22], zero fill[23]
    output logic [23:0]      m_axis_tdata,
    // send_kind[1:0]
    output logic [1:0]       m_axis_tuser
);

    localparam logic [15:0] DefaultBlock = 16'(DEFAULT_BLOCK);

    // configuration
    logic        r_dally_en;
    logic        r_bs_on;
    logic [15:0] r_bs_req;
    logic        r_to_on;
    logic [7:0]  r_to_req;
    logic        r_ts_on;

    // transfer state
    logic [15:0] r_last_block, n_last_block;
    logic [15:0] r_block_limit, n_block_limit;
    logic        r_oack_seen, n_oack_seen;

    // output register
    logic        r_out_valid;
    t_result     r_out, n_out;

    // unpacked input word
    logic [1:0]  in_kind;
    logic [15:0] in_blk;
    logic [15:0] in_size;
    logic        in_acc;
    logic        in_empty;
    logic        in_bs_valid;
    logic [15:0] in_bs_value;
    logic        in_to_valid;
    logic [7:0]  in_to_value;
    logic        in_ts_valid;
    logic        in_ts_fits;

    logic        s_fire;
    logic [15:0] next_block;
    logic        bs_bad;
    logic        to_bad;
    logic        tapply;

    assign in_kind     = s_axis_tuser;
    assign in_blk      = s_axis_tdata[15:0];
    assign in_size     = s_axis_tdata[31:16];
    assign in_acc      = s_axis_tdata[32];
    assign in_empty    = s_axis_tdata[33];
    assign in_bs_valid = s_axis_tdata[34];
    assign in_bs_value = s_axis_tdata[50:35];
    assign in_to_valid = s_axis_tdata[51];
    assign in_to_value = s_axis_tdata[59:52];
    assign in_ts_valid = s_axis_tdata[60];
    assign in_ts_fits  = s_axis_tdata[61];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign next_block = r_last_block + 16'd1;
    assign bs_bad = r_bs_on &&
                    (!in_bs_valid || (in_bs_value != 16'd0 && in_bs_value > r_bs_req));
    assign to_bad = r_to_on &&
                    (!in_to_valid || (in_to_value != 8'd0 && in_to_value != r_to_req));
    assign tapply = r_to_on && (in_to_value != 8'd0);

    always_comb begin
        n_last_block  = r_last_block;
        n_block_limit = r_block_limit;
        n_oack_seen   = r_oack_seen;
        n_out         = '{send_kind: SK_ERR, ack_block: 16'd0, error_code: EC_ILLEGAL,
                          transfer_state: TS_XFER_ERR, deliver_data: 1'b0,
                          timeout_apply: 1'b0};
        unique case (in_kind)
            KIND_START: begin
                n_last_block         = 16'd0;
                n_block_limit        = DefaultBlock;
                n_out.send_kind      = SK_RRQ;
                n_out.transfer_state = TS_RUN;
            end
            KIND_ACK: begin
                // unexpected ACK keeps the illegal-operation default
            end
            KIND_DATA: begin
                priority if (in_blk == r_last_block) begin
                    // duplicate block: acknowledge again, no delivery
                    n_out.send_kind      = SK_ACK;
                    n_out.ack_block      = r_last_block;
                    n_out.transfer_state = f_end_state(in_size, r_block_limit, r_dally_en);
                end else if (in_blk != next_block || in_size > r_block_limit) begin
                end else if (in_blk == 16'd1 && !r_oack_seen && !in_acc) begin
                    n_out.error_code = EC_REFUSED;
                end else begin
                    n_last_block         = next_block;
                    n_out.send_kind      = SK_ACK;
                    n_out.ack_block      = next_block;
                    n_out.transfer_state = f_end_state(in_size, r_block_limit, r_dally_en);
                    n_out.deliver_data   = 1'b1;
                end
            end
            KIND_OACK: begin
                if (r_last_block == 16'd0 && !in_empty) begin
                    n_out.error_code     = EC_REFUSED;
                    n_out.transfer_state = TS_OPT_ERR;
                    if (!bs_bad) begin
                        // an accepted block size stays even if a later check fails
                        if (r_bs_on && in_bs_value != 16'd0) begin
                            n_block_limit = in_bs_value;
                        end
                        if (!to_bad) begin
                            n_out.timeout_apply = tapply;
                            priority if (r_ts_on && !in_ts_valid) begin
                            end else if (r_ts_on && !in_ts_fits) begin
                                n_out.error_code = EC_DISKFULL;
                            end else if (!in_acc) begin
                            end else begin
                                n_oack_seen          = 1'b1;
                                n_out.send_kind      = SK_ACK;
                                n_out.error_code     = EC_ILLEGAL;
                                n_out.transfer_state = TS_RUN;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dally_en <= 1'b0;
            r_bs_on    <= 1'b0;
            r_bs_req   <= 16'd512;
            r_to_on    <= 1'b0;
            r_to_req   <= 8'd5;
            r_ts_on    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DALLY_EN:   r_dally_en <= i_cfg_wdata[0];
                CFG_BLKSIZE_ON: r_bs_on    <= i_cfg_wdata[0];
                CFG_BLKSIZE_RQ: r_bs_req   <= i_cfg_wdata;
                CFG_TIMEOUT_ON: r_to_on    <= i_cfg_wdata[0];
                CFG_TIMEOUT_RQ: r_to_req   <= i_cfg_wdata[7:0];
                CFG_TSIZE_ON:   r_ts_on    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_block  <= 16'd0;
            r_block_limit <= DefaultBlock;
            r_oack_seen   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_fire) begin
                r_last_block  <= n_last_block;
                r_block_limit <= n_block_limit;
                r_oack_seen   <= n_oack_seen;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.send_kind;
    assign m_axis_tdata  = {1'b0, r_out.timeout_apply, r_out.deliver_data,
                            r_out.transfer_state, r_out.error_code, r_out.ack_block};

`ifndef SYNTHESIS
    // A start request always rewinds the block counter.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && in_kind == KIND_START |=> r_last_block == 16'd0)
        else $error("start did not clear last block");

    // A delivered block is the one now recorded as last.
    a_deliver_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.deliver_data |-> r_out.ack_block == r_last_block)
        else $error("delivered block differs from last block");

    // An ERROR answer never carries an ACK number or delivers data.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.send_kind == SK_ERR |->
            r_out.ack_block == 16'd0 && !r_out.deliver_data)
        else $error("error answer carries ack data");

    // The block limit never becomes zero.
    a_limit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_limit != 16'd0)
        else $error("block limit is zero");
`endif

endmodule

`default_nettype wire
